// ===== hdl/pfde_pkg.sv =====
// Shared types and constants for the page framebuffer draw engine.
`timescale 1ns / 1ps
package pfde_pkg;
   localparam int PAGE_ROWS = 8;
   localparam int WORDS_PER_PAGE = 16;
   localparam int BYTES_PER_WORD = 8;

   typedef enum logic [2:0] {
      CMD_FILL_ALL   = 3'd0,
      CMD_SET_PIXEL  = 3'd1,
      CMD_READ_PIXEL = 3'd2,
      CMD_FILL_RECT  = 3'd3,
      CMD_FILL_DISC  = 3'd4,
      CMD_READ_PAGE  = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PIX_RD,
      ST_PIX_WB,
      ST_SHAPE_RD,
      ST_SHAPE_WB,
      ST_PAGE_RD,
      ST_PAGE_COL,
      ST_PAGE_OUT
   } state_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_PAGE  = 1'b1
   } kind_type;
endpackage

// ===== hdl/pfde_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/page_framebuffer_draw_engine_core.sv =====
// Top level of the page framebuffer draw engine: command sequencer and frame store.
//
//   channel | ports                 | direction | contents
//   req     | req_tvalid/tready/... | in        | draw and read commands
//   rsp     | rsp_tvalid/tready/... | out       | pixel answers and page words
//
// The store is one byte-wide memory; every pixel change is a read, modify and
// write back of its byte, and fill all writes one byte a cycle.
// A rectangle or disc walks its bounding box pixel by pixel, reading and writing
// back each pixel inside the shape; a page readout gathers eight bytes per word, sixteen words in all.
// After reset a clearing pass zeroes every byte before any transfer.
// Results wait in an output register; the sequencer holds a new result while it is full.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_core #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], x_pos[12:3], y_pos[22:13], span_or_radius[30:23],
   // rect_height[38:31], pixel_on[39], page_index[42:40], zeros up to 47
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_value[0], page_word[64:1], zeros up to 71
   output logic [71:0] rsp_tdata,
   // result_kind
   output logic        rsp_tuser,
   // last_word
   output logic        rsp_tlast
);
   import pfde_pkg::*;

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int AW          = $clog2(STORE_BYTES);

   state_type state_ff, state_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic [2:0] cmd_ff;
   logic signed [9:0] x0_ff, y0_ff;
   logic [7:0] span_ff, tall_ff;
   logic lit_ff;
   logic [2:0] page_ff;
   logic signed [10:0] di_ff, di_in, dj_ff, dj_in;
   logic [3:0] word_ff, word_in;
   logic [2:0] col_ff, col_in;
   logic [63:0] acc_ff, acc_in;

   logic out_valid_ff, out_valid_in;
   logic out_kind_ff, out_pix_ff, out_last_ff;
   logic [63:0] out_word_ff;
   logic load_out;
   logic load_kind, load_pix, load_last;
   logic [63:0] load_word;

   logic wr_en;
   logic [AW-1:0] addr;
   logic [7:0] wr_data, rd_data;

   logic signed [11:0] px, py;
   logic on_screen;
   logic [AW-1:0] pix_addr;
   logic [2:0] pix_bit;
   logic [7:0] col_num;
   logic col_ok;
   logic [AW-1:0] page_addr;
   logic signed [21:0] dd;
   logic [15:0] rr;
   logic in_shape;
   logic step_last;

   pfde_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // Current pixel under the walk.
   always_comb begin
      if (cmd_ff == CMD_FILL_RECT) begin
         px = 12'(x0_ff) + 12'(di_ff);
         py = 12'(y0_ff) + 12'(dj_ff);
      end else if (cmd_ff == CMD_FILL_DISC) begin
         px = 12'(x0_ff) + 12'(di_ff);
         py = 12'(y0_ff) + 12'(dj_ff);
      end else begin
         px = 12'(x0_ff);
         py = 12'(y0_ff);
      end
      on_screen = (px >= 0) && (px < DISPLAY_WIDTH) && (py >= 0) && (py < DISPLAY_HEIGHT);
      pix_addr = AW'((32'(py) >> 3) * DISPLAY_WIDTH + 32'(px));
      pix_bit = py[2:0];
      dd = 22'(di_ff) * 22'(di_ff) + 22'(dj_ff) * 22'(dj_ff);
      rr = 16'(span_ff) * 16'(span_ff);
      in_shape = (cmd_ff == CMD_FILL_RECT) ? 1'b1 : (dd <= 22'(rr));
      if (cmd_ff == CMD_FILL_RECT) begin
         step_last = (di_ff == 11'(span_ff) - 11'sd1) && (dj_ff == 11'(tall_ff) - 11'sd1);
      end else begin
         step_last = (di_ff == 11'(span_ff)) && (dj_ff == 11'(span_ff));
      end
      col_num = {1'b0, word_ff, col_ff};
      col_ok = (32'(col_num) < DISPLAY_WIDTH) && (32'(page_ff) < PAGE_COUNT);
      page_addr = AW'(32'(page_ff) * DISPLAY_WIDTH + 32'(col_num));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (cnt_ff == (AW+1)'(STORE_BYTES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tdata[2:0])
                  CMD_FILL_ALL:   state_in = ST_FILL;
                  CMD_SET_PIXEL:  state_in = ST_PIX_RD;
                  CMD_READ_PIXEL: state_in = ST_PIX_RD;
                  CMD_FILL_RECT: begin
                     if (req_tdata[30:23] != 8'd0 && req_tdata[38:31] != 8'd0)
                        state_in = ST_SHAPE_RD;
                  end
                  CMD_FILL_DISC:  state_in = ST_SHAPE_RD;
                  CMD_READ_PAGE:  state_in = ST_PAGE_RD;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: if (cnt_ff == (AW+1)'(STORE_BYTES - 1)) state_in = ST_IDLE;
         ST_PIX_RD: state_in = ST_PIX_WB;
         ST_PIX_WB: if (cmd_ff == CMD_SET_PIXEL || !out_valid_ff) state_in = ST_IDLE;
         ST_SHAPE_RD: state_in = ST_SHAPE_WB;
         ST_SHAPE_WB: state_in = step_last ? ST_IDLE : ST_SHAPE_RD;
         ST_PAGE_RD: state_in = ST_PAGE_COL;
         ST_PAGE_COL: state_in = (col_ff == 3'd7) ? ST_PAGE_OUT : ST_PAGE_RD;
         ST_PAGE_OUT: begin
            if (!out_valid_ff) state_in = (word_ff == 4'd15) ? ST_IDLE : ST_PAGE_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      cnt_in = cnt_ff;
      di_in = di_ff;
      dj_in = dj_ff;
      word_in = word_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      wr_en = 1'b0;
      addr = pix_addr;
      wr_data = 8'd0;
      load_out = 1'b0;
      load_kind = KIND_PIXEL;
      load_pix = 1'b0;
      load_last = 1'b0;
      load_word = 64'd0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            addr = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in = '0;
            word_in = 4'd0;
            col_in = 3'd0;
            acc_in = 64'd0;
            if (req_tdata[2:0] == CMD_FILL_DISC) begin
               di_in = -11'(req_tdata[30:23]);
               dj_in = -11'(req_tdata[30:23]);
            end else begin
               di_in = 11'sd0;
               dj_in = 11'sd0;
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            addr = cnt_ff[AW-1:0];
            wr_data = lit_ff ? 8'hFF : 8'h00;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_PIX_RD: ;
         ST_PIX_WB: begin
            if (cmd_ff == CMD_SET_PIXEL) begin
               wr_en = on_screen;
               wr_data = lit_ff ? (rd_data | (8'd1 << pix_bit))
                                : (rd_data & ~(8'd1 << pix_bit));
            end else if (!out_valid_ff) begin
               load_out = 1'b1;
               load_pix = on_screen & rd_data[pix_bit];
            end
         end
         ST_SHAPE_RD: ;
         ST_SHAPE_WB: begin
            wr_en = on_screen & in_shape;
            wr_data = lit_ff ? (rd_data | (8'd1 << pix_bit))
                             : (rd_data & ~(8'd1 << pix_bit));
            if ((cmd_ff == CMD_FILL_RECT && di_ff == 11'(span_ff) - 11'sd1) ||
                (cmd_ff == CMD_FILL_DISC && di_ff == 11'(span_ff))) begin
               di_in = (cmd_ff == CMD_FILL_DISC) ? -11'(span_ff) : 11'sd0;
               dj_in = dj_ff + 11'sd1;
            end else begin
               di_in = di_ff + 11'sd1;
            end
         end
         ST_PAGE_RD: addr = page_addr;
         ST_PAGE_COL: begin
            addr = page_addr;
            acc_in = acc_ff | ((col_ok ? 64'(rd_data) : 64'd0) << {col_ff, 3'b000});
            col_in = col_ff + 3'd1;
         end
         ST_PAGE_OUT: begin
            addr = page_addr;
            if (!out_valid_ff) begin
               load_out = 1'b1;
               load_kind = KIND_PAGE;
               load_word = acc_ff;
               load_last = (word_ff == 4'd15);
               acc_in = 64'd0;
               col_in = 3'd0;
               word_in = word_ff + 4'd1;
            end
         end
         default: ;
      endcase
   end

   assign out_valid_in = load_out | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      di_ff <= di_in;
      dj_ff <= dj_in;
      word_ff <= word_in;
      col_ff <= col_in;
      acc_ff <= acc_in;
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata[2:0];
         x0_ff <= req_tdata[12:3];
         y0_ff <= req_tdata[22:13];
         span_ff <= req_tdata[30:23];
         tall_ff <= req_tdata[38:31];
         lit_ff <= req_tdata[39];
         page_ff <= req_tdata[42:40];
      end
      if (load_out) begin
         out_kind_ff <= load_kind;
         out_pix_ff <= load_pix;
         out_word_ff <= load_word;
         out_last_ff <= load_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, out_word_ff, out_pix_ff};
   assign rsp_tuser = out_kind_ff;
   assign rsp_tlast = out_last_ff;
endmodule

// ===== test/pfde_checker.sv =====
// Checker for the page framebuffer draw engine: frame store model and result comparison.
`timescale 1ns / 1ps
module pfde_checker #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count,
   output int          pixel_answers,
   output int          page_words
);
   import pfde_pkg::*;

   localparam int PAGES = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;

   typedef struct packed {
      kind_type    kind;
      logic        pixel;
      logic [63:0] word;
      logic        last;
   } answer_type;

   logic [7:0] shadow_store [DISPLAY_WIDTH*PAGES];
   answer_type answer_queue [$];

   assign pending_count = answer_queue.size();

   function automatic bit on_screen(int x, int y);
      return x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT;
   endfunction

   task automatic plot(int x, int y, logic lit);
      int pos;
      if (on_screen(x, y)) begin
         pos = (y / PAGE_ROWS) * DISPLAY_WIDTH + x;
         shadow_store[pos][y % PAGE_ROWS] = lit;
      end
   endtask

   task automatic apply_command(logic [47:0] d);
      cmd_type    cmd;
      int         x0, y0, span, tall, i, j, k, n, col;
      logic       lit;
      int         page;
      answer_type a;
      cmd  = cmd_type'(d[2:0]);
      x0   = int'($signed(d[12:3]));
      y0   = int'($signed(d[22:13]));
      span = int'(d[30:23]);
      tall = int'(d[38:31]);
      lit  = d[39];
      page = int'(d[42:40]);
      case (cmd)
         CMD_FILL_ALL: begin
            foreach (shadow_store[p]) shadow_store[p] = {8{lit}};
         end
         CMD_SET_PIXEL: plot(x0, y0, lit);
         CMD_READ_PIXEL: begin
            a = '0;
            a.kind = KIND_PIXEL;
            if (on_screen(x0, y0))
               a.pixel = shadow_store[(y0 / PAGE_ROWS) * DISPLAY_WIDTH + x0][y0 % PAGE_ROWS];
            answer_queue.push_back(a);
         end
         CMD_FILL_RECT: begin
            for (j = y0; j < y0 + tall; j++)
               for (i = x0; i < x0 + span; i++) plot(i, j, lit);
         end
         CMD_FILL_DISC: begin
            for (j = -span; j <= span; j++)
               for (i = -span; i <= span; i++)
                  if (i * i + j * j <= span * span) plot(x0 + i, y0 + j, lit);
         end
         CMD_READ_PAGE: begin
            for (k = 0; k < WORDS_PER_PAGE; k++) begin
               a = '0;
               a.kind = KIND_PAGE;
               for (n = 0; n < BYTES_PER_WORD; n++) begin
                  col = k * BYTES_PER_WORD + n;
                  if (col < DISPLAY_WIDTH && page < PAGES)
                     a.word[n*8 +: 8] = shadow_store[page * DISPLAY_WIDTH + col];
               end
               a.last = (k == WORDS_PER_PAGE - 1);
               answer_queue.push_back(a);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      answer_type exp_a, got;
      if (reset) begin
         foreach (shadow_store[p]) shadow_store[p] = 8'h00;
         answer_queue.delete();
         fail_count    <= 0;
         pixel_answers <= 0;
         page_words    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = kind_type'(rsp_tuser);
            got.pixel = rsp_tdata[0];
            got.word  = rsp_tdata[64:1];
            got.last  = rsp_tlast;
            if (got.kind == KIND_PIXEL) pixel_answers <= pixel_answers + 1;
            else page_words <= page_words + 1;
            if (answer_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected result transfer: kind %0d pixel %0d word %h last %0d",
                           got.kind, got.pixel, got.word, got.last);
               fail_count <= fail_count + 1;
            end else begin
               exp_a = answer_queue.pop_front();
               if (got !== exp_a) begin
                  if (fail_count < 10)
                     $display({"Mismatch: expected kind %0d pixel %0d word %h last %0d,",
                               " got kind %0d pixel %0d word %h last %0d"},
                              exp_a.kind, exp_a.pixel, exp_a.word, exp_a.last,
                              got.kind, got.pixel, got.word, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) apply_command(req_tdata);
      end
   end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the page framebuffer draw engine: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import pfde_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count, pending_count, pixel_answers, page_words;
   bit          quiet_phase = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_framebuffer_draw_engine_core u_dut (.*);

   pfde_checker u_checker (.*);

   initial begin
      #500ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [47:0] pack_command(cmd_type cmd, int x, int y, int span,
                                                int tall, bit lit, int page);
      logic [47:0] d;
      d = '0;
      d[2:0]   = cmd;
      d[12:3]  = x[9:0];
      d[22:13] = y[9:0];
      d[30:23] = span[7:0];
      d[38:31] = tall[7:0];
      d[39]    = lit;
      d[42:40] = page[2:0];
      return d;
   endfunction

   task automatic send_command(logic [47:0] d);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_command();
      int r, x, y;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom_range(0, 1023);
         y = $urandom_range(0, 1023);
      end else begin
         x = $urandom_range(0, 135) - 4;
         y = $urandom_range(0, 71) - 4;
      end
      if (r < 30)
         send_command(pack_command(CMD_SET_PIXEL, x, y, $urandom, $urandom, $urandom, $urandom));
      else if (r < 60)
         send_command(pack_command(CMD_READ_PIXEL, x, y, $urandom, $urandom, $urandom, $urandom));
      else if (r < 72)
         send_command(pack_command(CMD_FILL_RECT, x, y, $urandom_range(0, 12),
                                   $urandom_range(0, 12), $urandom, $urandom));
      else if (r < 80)
         send_command(pack_command(CMD_FILL_DISC, x, y, $urandom_range(0, 6),
                                   $urandom, $urandom, $urandom));
      else if (r < 90)
         send_command(pack_command(CMD_READ_PAGE, x, y, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 7)));
      else if (r < 93)
         send_command(pack_command(CMD_FILL_ALL, x, y, $urandom, $urandom, $urandom, $urandom));
      else if (r < 96)
         send_command(pack_command(cmd_type'($urandom_range(6, 7)), x, y, $urandom,
                                   $urandom, $urandom, $urandom));
      else if (r < 98)
         send_command(pack_command(CMD_FILL_RECT, x, y, $urandom_range(100, 255),
                                   $urandom_range(30, 255), $urandom, $urandom));
      else
         send_command(pack_command(CMD_FILL_DISC, x, y, $urandom_range(20, 255),
                                   $urandom, $urandom, $urandom));
   endtask

   initial begin
      int i, wait_cycles;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_command(pack_command(CMD_READ_PAGE, 0, 0, 0, 0, 0, 0));
      send_command(pack_command(CMD_SET_PIXEL, 0, 0, 0, 0, 1, 0));
      send_command(pack_command(CMD_SET_PIXEL, 127, 63, 0, 0, 1, 0));
      send_command(pack_command(CMD_SET_PIXEL, 128, 64, 0, 0, 1, 0));
      send_command(pack_command(CMD_SET_PIXEL, -512, -1, 0, 0, 1, 0));
      send_command(pack_command(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 0));
      send_command(pack_command(CMD_READ_PIXEL, 127, 63, 255, 255, 1, 7));
      send_command(pack_command(CMD_READ_PIXEL, 511, 511, 0, 0, 0, 0));
      send_command(pack_command(CMD_READ_PIXEL, -1, 5, 0, 0, 0, 0));
      send_command(pack_command(CMD_FILL_RECT, 10, 3, 0, 20, 1, 0));
      send_command(pack_command(CMD_FILL_RECT, 10, 3, 20, 0, 1, 0));
      send_command(pack_command(CMD_FILL_RECT, -5, -5, 20, 14, 1, 0));
      send_command(pack_command(CMD_FILL_RECT, 120, 60, 255, 255, 1, 0));
      send_command(pack_command(CMD_FILL_DISC, 64, 32, 0, 0, 1, 0));
      send_command(pack_command(CMD_FILL_DISC, 40, 20, 7, 0, 1, 0));
      send_command(pack_command(CMD_FILL_DISC, 0, 63, 5, 0, 0, 0));
      send_command(pack_command(CMD_READ_PAGE, 0, 0, 0, 0, 0, 0));
      send_command(pack_command(CMD_READ_PAGE, 0, 0, 0, 0, 0, 7));
      send_command(pack_command(cmd_type'(3'd6), 1, 1, 1, 1, 1, 1));
      send_command(pack_command(cmd_type'(3'd7), 2, 2, 2, 2, 1, 2));
      send_command(pack_command(CMD_FILL_ALL, 0, 0, 0, 0, 1, 0));
      send_command(pack_command(CMD_READ_PAGE, 0, 0, 0, 0, 0, 3));
      send_command(pack_command(CMD_READ_PIXEL, 100, 50, 0, 0, 0, 0));
      send_command(pack_command(CMD_FILL_ALL, 0, 0, 0, 0, 0, 0));
      send_command(pack_command(CMD_READ_PIXEL, 100, 50, 0, 0, 0, 0));

      for (i = 0; i < 400; i++) begin
         if (i == 340) quiet_phase = 1'b1;
         send_random_command();
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2000) @(posedge clock);
      $display("Covered all six commands, the unused codes, clipping and empty shapes.");
      $display("Checked %0d pixel answers and %0d page words.", pixel_answers, page_words);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== page_framebuffer_draw_engine_core.f =====
hdl/pfde_pkg.sv
hdl/pfde_ram.sv
hdl/page_framebuffer_draw_engine_core.sv
test/pfde_checker.sv
test/tb_top.sv
